### src/tilt_complementary_filter_core_macros.svh
// Assertion helpers shared by the RTL.
`ifndef TILT_COMPLEMENTARY_FILTER_CORE_MACROS_SVH
`define TILT_COMPLEMENTARY_FILTER_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define TCF_ASSERT_IMPL(lbl, clk, rst_n, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("tcf assertion failed");

// Next-cycle implication, disabled in reset.
`define TCF_ASSERT_NEXT(lbl, clk, rst_n, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("tcf assertion failed");

`endif

### src/tcf_pkg.sv
package tcf_pkg;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic [19:0]        elapsed_us;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] roll_angle;
    logic signed [31:0] pitch_angle;
    logic [7:0]         roll_command;
    logic [7:0]         pitch_command;
  } out_word_t;

  typedef enum logic [2:0] {
    REG_BLEND_WEIGHT = 3'd0,
    REG_GYRO_GAIN    = 3'd1,
    REG_INTERVAL_CAP = 3'd2,
    REG_ROLL_MIN     = 3'd3,
    REG_ROLL_MAX     = 3'd4,
    REG_PITCH_CENTER = 3'd5
  } reg_idx_t;

  localparam int CORDIC_STEPS = 20;
  localparam int CORDIC_N     = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int CORDIC_IN_W  = 18;
  localparam int CORDIC_W     = 38;
  localparam int ANGLE_W      = 24;
  localparam logic signed [ANGLE_W-1:0] PI_Q20 = 24'sd3294199;

  localparam int MUL_A_W     = 40;
  localparam int MUL_B_W     = 24;
  localparam int MUL_P_W     = 64;
  localparam int MUL_DIGIT_W = 4;
  localparam int MUL_DIGITS  = MUL_B_W / MUL_DIGIT_W;
  localparam int MUL_CNT_W   = $clog2(MUL_DIGITS);

  localparam logic [MUL_B_W-1:0] TWO_DEG_PER_RAD_Q16 = 24'd7509872;
  localparam logic [MUL_B_W-1:0] DEG_PER_RAD_Q16     = 24'd3754936;

  function automatic logic signed [ANGLE_W-1:0] atan_q20(input logic [4:0] idx);
    logic signed [ANGLE_W-1:0] v;
    case (idx)
      5'd0:    v = 24'sd823550;
      5'd1:    v = 24'sd486170;
      5'd2:    v = 24'sd256879;
      5'd3:    v = 24'sd130396;
      5'd4:    v = 24'sd65451;
      5'd5:    v = 24'sd32757;
      5'd6:    v = 24'sd16383;
      5'd7:    v = 24'sd8192;
      5'd8:    v = 24'sd4096;
      5'd9:    v = 24'sd2048;
      5'd10:   v = 24'sd1024;
      5'd11:   v = 24'sd512;
      5'd12:   v = 24'sd256;
      5'd13:   v = 24'sd128;
      5'd14:   v = 24'sd64;
      5'd15:   v = 24'sd32;
      5'd16:   v = 24'sd16;
      5'd17:   v = 24'sd8;
      5'd18:   v = 24'sd4;
      5'd19:   v = 24'sd2;
      5'd20:   v = 24'sd1;
      default: v = 24'sd0;
    endcase
    return v;
  endfunction

  // Round to nearest, ties away from zero.
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                    input int unsigned s);
    logic [63:0] mag;
    logic [63:0] q;
    mag = v[63] ? 64'(-v) : 64'(v);
    q = (mag + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [7:0] sat180(input logic signed [63:0] v);
    logic [7:0] r;
    if (v < 64'sd0) r = 8'd0;
    else if (v > 64'sd180) r = 8'd180;
    else r = v[7:0];
    return r;
  endfunction

endpackage

### src/tcf_cordic.sv
module tcf_cordic (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  input  logic signed [tcf_pkg::CORDIC_IN_W-1:0]  y_in,
  input  logic signed [tcf_pkg::CORDIC_IN_W-1:0]  x_in,
  output logic                                    busy,
  output logic                                    done,
  output logic signed [tcf_pkg::ANGLE_W-1:0]      angle
);

  logic signed [tcf_pkg::CORDIC_W-1:0] x_r, y_r, xe, ye, dx, dy;
  logic signed [tcf_pkg::ANGLE_W-1:0]  z_r;
  logic [4:0]                          i_r;
  logic                                busy_r, done_r;

  assign xe = tcf_pkg::CORDIC_W'(x_in) <<< 16;
  assign ye = tcf_pkg::CORDIC_W'(y_in) <<< 16;
  assign dx = y_r >>> i_r;
  assign dy = x_r >>> i_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        i_r <= '0;
        if (x_in == '0 && y_in == '0) begin
          z_r    <= '0;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          if (x_in < 0) begin
            x_r <= -xe;
            y_r <= -ye;
            z_r <= (y_in >= 0) ? tcf_pkg::PI_Q20 : -tcf_pkg::PI_Q20;
          end else begin
            x_r <= xe;
            y_r <= ye;
            z_r <= '0;
          end
        end
      end else if (busy_r) begin
        if (y_r > 0) begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + tcf_pkg::atan_q20(i_r);
        end else begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - tcf_pkg::atan_q20(i_r);
        end
        i_r <= i_r + 5'd1;
        if (i_r == 5'(tcf_pkg::CORDIC_N - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy  = busy_r;
  assign done  = done_r;
  assign angle = z_r;

endmodule

### src/tcf_sermul.sv
module tcf_sermul (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [tcf_pkg::MUL_A_W-1:0]    a_in,
  input  logic [tcf_pkg::MUL_B_W-1:0]           b_in,
  output logic                                  busy,
  output logic                                  done,
  output logic signed [tcf_pkg::MUL_P_W-1:0]    product
);

  logic signed [tcf_pkg::MUL_A_W-1:0]                 a_r;
  logic [tcf_pkg::MUL_B_W-1:0]                        b_r;
  logic signed [tcf_pkg::MUL_P_W-1:0]                 p_r;
  logic [tcf_pkg::MUL_CNT_W-1:0]                      cnt_r;
  logic                                               busy_r, done_r;
  logic [tcf_pkg::MUL_DIGIT_W-1:0]                    dig;
  logic signed [tcf_pkg::MUL_A_W+tcf_pkg::MUL_DIGIT_W:0] part;

  // Most significant digit first: shift the partial sum, add one row.
  assign dig  = b_r[tcf_pkg::MUL_B_W-1 -: tcf_pkg::MUL_DIGIT_W];
  assign part = a_r * $signed({1'b0, dig});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r    <= a_in;
        b_r    <= b_in;
        p_r    <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        p_r   <= (p_r <<< tcf_pkg::MUL_DIGIT_W) + tcf_pkg::MUL_P_W'(part);
        b_r   <= b_r << tcf_pkg::MUL_DIGIT_W;
        cnt_r <= cnt_r + tcf_pkg::MUL_CNT_W'(1);
        if (cnt_r == tcf_pkg::MUL_CNT_W'(tcf_pkg::MUL_DIGITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy    = busy_r;
  assign done    = done_r;
  assign product = p_r;

endmodule

### src/tilt_complementary_filter_core.sv
// Channel  | Handshake                 | Word
// ---------+---------------------------+------------------------------------------
// in_      | in_valid / in_stall       | tcf_pkg::in_word_t  (one IMU sample)
// out_     | out_valid / out_stall     | tcf_pkg::out_word_t (angles and commands)
// cfg      | psel/penable/pwrite/pready| 32-bit APB registers at 4*index
//
// One sample runs in sequence through ten products on the 4-bit serial
// multiplier, 16 root digits, two CORDIC runs and one write-back. in_stall
// stays high until that write-back, so the next sample is taken only after it.
// Reset is synchronous (rst_n low); it restores register defaults, zero angles
// and a last roll command of 90 degrees.
// A result word holds in the output register while out_stall is high; the
// next sample is taken meanwhile and waits only at its final write-back.
`include "tilt_complementary_filter_core_macros.svh"

module tilt_complementary_filter_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tcf_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tcf_pkg::out_word_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ_Y, ST_SQ_Z, ST_SQRT, ST_CORD_R, ST_CORD_P,
    ST_G_MUL1, ST_G_MUL2, ST_BLEND, ST_CMD_R, ST_CMD_P, ST_FIN
  } state_t;

  // Configuration registers.
  logic [15:0] blend_weight_r;
  logic [23:0] gyro_gain_r;
  logic [19:0] interval_cap_r;
  logic [7:0]  roll_min_r, roll_max_r, pitch_center_r;
  tcf_pkg::reg_idx_t cfg_idx;

  // Working state.
  state_t              state_r;
  logic                wait_r;
  logic                axis_r;
  tcf_pkg::in_word_t   in_r;
  logic [19:0]         dt_r;
  logic [31:0]         sq_r;
  logic [17:0]         rem_r;
  logic [15:0]         root_r;
  logic [3:0]          sq_cnt_r;
  logic signed [23:0]  acc_roll_r, acc_pitch_r;
  logic signed [39:0]  t_r;
  logic signed [33:0]  gyro_r;
  logic signed [31:0]  roll_est_r, pitch_est_r;
  logic [7:0]          last_roll_cmd_r, pitch_cmd_r;
  tcf_pkg::out_word_t  out_r;
  logic                out_valid_r;

  // Shared units.
  logic                                 mul_start, mul_busy, mul_done;
  logic signed [tcf_pkg::MUL_A_W-1:0]   mul_a;
  logic [tcf_pkg::MUL_B_W-1:0]          mul_b;
  logic signed [tcf_pkg::MUL_P_W-1:0]   mul_p;
  logic                                 cord_start, cord_busy, cord_done;
  logic signed [tcf_pkg::CORDIC_IN_W-1:0] cord_y, cord_x;
  logic signed [tcf_pkg::ANGLE_W-1:0]   cord_z;

  logic signed [16:0]  ay_e, az_e, ay_abs, az_abs;
  logic signed [31:0]  est_sel;
  logic signed [23:0]  acc_sel;
  logic signed [15:0]  rate_sel;
  logic signed [63:0]  step, blend_v, cmd_v;
  logic [19:0]         rem_t;
  logic [17:0]         trial;
  logic                is_mul, is_cord, out_free;

  assign cfg_idx = tcf_pkg::reg_idx_t'(paddr[4:2]);
  assign pready  = 1'b1;

  always_comb begin
    case (cfg_idx)
      tcf_pkg::REG_BLEND_WEIGHT: prdata = 32'(blend_weight_r);
      tcf_pkg::REG_GYRO_GAIN:    prdata = 32'(gyro_gain_r);
      tcf_pkg::REG_INTERVAL_CAP: prdata = 32'(interval_cap_r);
      tcf_pkg::REG_ROLL_MIN:     prdata = 32'(roll_min_r);
      tcf_pkg::REG_ROLL_MAX:     prdata = 32'(roll_max_r);
      tcf_pkg::REG_PITCH_CENTER: prdata = 32'(pitch_center_r);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_weight_r <= 16'd61604;
      gyro_gain_r    <= 24'd1200030;
      interval_cap_r <= 20'd50000;
      roll_min_r     <= 8'd60;
      roll_max_r     <= 8'd120;
      pitch_center_r <= 8'd90;
    end else if (psel && penable && pwrite) begin
      case (cfg_idx)
        tcf_pkg::REG_BLEND_WEIGHT: blend_weight_r <= pwdata[15:0];
        tcf_pkg::REG_GYRO_GAIN:    gyro_gain_r    <= pwdata[23:0];
        tcf_pkg::REG_INTERVAL_CAP: interval_cap_r <= pwdata[19:0];
        tcf_pkg::REG_ROLL_MIN:     roll_min_r     <= pwdata[7:0];
        tcf_pkg::REG_ROLL_MAX:     roll_max_r     <= pwdata[7:0];
        tcf_pkg::REG_PITCH_CENTER: pitch_center_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Operand selection for the shared multiplier and CORDIC.
  assign ay_e   = 17'(in_r.accel_y);
  assign az_e   = 17'(in_r.accel_z);
  assign ay_abs = ay_e[16] ? -ay_e : ay_e;
  assign az_abs = az_e[16] ? -az_e : az_e;

  assign est_sel  = axis_r ? pitch_est_r : roll_est_r;
  assign acc_sel  = axis_r ? acc_pitch_r : acc_roll_r;
  assign rate_sel = axis_r ? in_r.rate_y : in_r.rate_x;

  always_comb begin
    is_mul = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      ST_SQ_Y: begin
        mul_a = 40'(ay_abs);
        mul_b = 24'(ay_abs[15:0]);
      end
      ST_SQ_Z: begin
        mul_a = 40'(az_abs);
        mul_b = 24'(az_abs[15:0]);
      end
      ST_G_MUL1: begin
        mul_a = 40'(rate_sel);
        mul_b = gyro_gain_r;
      end
      ST_G_MUL2: begin
        mul_a = t_r;
        mul_b = 24'(dt_r);
      end
      // alpha*gyro + (1-alpha)*acc == acc + alpha*(gyro - acc)
      ST_BLEND: begin
        mul_a = 40'(35'(gyro_r) - 35'(acc_sel));
        mul_b = 24'(blend_weight_r);
      end
      ST_CMD_R: begin
        mul_a = 40'(roll_est_r);
        mul_b = tcf_pkg::TWO_DEG_PER_RAD_Q16;
      end
      ST_CMD_P: begin
        mul_a = 40'(pitch_est_r);
        mul_b = tcf_pkg::DEG_PER_RAD_Q16;
      end
      default: is_mul = 1'b0;
    endcase
  end

  assign is_cord = (state_r == ST_CORD_R) || (state_r == ST_CORD_P);
  assign cord_y  = (state_r == ST_CORD_P) ? -(18'(in_r.accel_x)) : 18'(in_r.accel_y);
  assign cord_x  = (state_r == ST_CORD_P) ? $signed({2'b00, root_r}) : 18'(in_r.accel_z);

  assign mul_start  = is_mul && !wait_r;
  assign cord_start = is_cord && !wait_r;

  tcf_sermul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a_in    (mul_a),
    .b_in    (mul_b),
    .busy    (mul_busy),
    .done    (mul_done),
    .product (mul_p)
  );

  tcf_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .y_in  (cord_y),
    .x_in  (cord_x),
    .busy  (cord_busy),
    .done  (cord_done),
    .angle (cord_z)
  );

  // Post-processing of finished products.
  assign step    = tcf_pkg::rnd_shift(mul_p, 32);
  assign blend_v = tcf_pkg::rnd_shift(mul_p + (64'(acc_sel) <<< 16), 16);
  assign cmd_v   = tcf_pkg::rnd_shift(mul_p + $signed(64'(state_r == ST_CMD_R ?
                     last_roll_cmd_r : pitch_center_r) << 36), 36);

  // One root digit per cycle: two radicand bits in, one root bit out.
  assign rem_t = {rem_r, sq_r[31:30]};
  assign trial = {root_r, 2'b01};

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      wait_r          <= 1'b0;
      axis_r          <= 1'b0;
      roll_est_r      <= '0;
      pitch_est_r     <= '0;
      last_roll_cmd_r <= 8'd90;
      out_valid_r     <= 1'b0;
    end else begin
      // Raise valid on write-back, drop it once the word is taken.
      if (state_r == ST_FIN && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (mul_start || cord_start) wait_r <= 1'b1;
      if (mul_done || cord_done) wait_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            in_r    <= in_data;
            dt_r    <= (in_data.elapsed_us > interval_cap_r) ? interval_cap_r
                                                             : in_data.elapsed_us;
            state_r <= ST_SQ_Y;
          end
        end
        ST_SQ_Y: begin
          if (mul_done) begin
            sq_r    <= mul_p[31:0];
            state_r <= ST_SQ_Z;
          end
        end
        ST_SQ_Z: begin
          if (mul_done) begin
            sq_r     <= sq_r + mul_p[31:0];
            rem_r    <= '0;
            root_r   <= '0;
            sq_cnt_r <= '0;
            state_r  <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          sq_r     <= sq_r << 2;
          sq_cnt_r <= sq_cnt_r + 4'd1;
          if (rem_t >= 20'(trial)) begin
            rem_r  <= 18'(rem_t - 20'(trial));
            root_r <= {root_r[14:0], 1'b1};
          end else begin
            rem_r  <= rem_t[17:0];
            root_r <= {root_r[14:0], 1'b0};
          end
          if (sq_cnt_r == 4'd15) state_r <= ST_CORD_R;
        end
        ST_CORD_R: begin
          if (cord_done) begin
            acc_roll_r <= cord_z;
            state_r    <= ST_CORD_P;
          end
        end
        ST_CORD_P: begin
          if (cord_done) begin
            acc_pitch_r <= cord_z;
            axis_r      <= 1'b0;
            state_r     <= ST_G_MUL1;
          end
        end
        ST_G_MUL1: begin
          if (mul_done) begin
            t_r     <= mul_p[39:0];
            state_r <= ST_G_MUL2;
          end
        end
        ST_G_MUL2: begin
          if (mul_done) begin
            gyro_r  <= 34'(est_sel) + step[33:0];
            state_r <= ST_BLEND;
          end
        end
        ST_BLEND: begin
          if (mul_done) begin
            if (axis_r) begin
              pitch_est_r <= tcf_pkg::sat32(blend_v);
              state_r     <= ST_CMD_R;
            end else begin
              roll_est_r <= tcf_pkg::sat32(blend_v);
              axis_r     <= 1'b1;
              state_r    <= ST_G_MUL1;
            end
          end
        end
        ST_CMD_R: begin
          // Lower clamp wins over the upper one, then hold within 0..180.
          if (mul_done) begin
            if (cmd_v < $signed(64'(roll_min_r)))
              last_roll_cmd_r <= tcf_pkg::sat180($signed(64'(roll_min_r)));
            else if (cmd_v > $signed(64'(roll_max_r)))
              last_roll_cmd_r <= tcf_pkg::sat180($signed(64'(roll_max_r)));
            else
              last_roll_cmd_r <= tcf_pkg::sat180(cmd_v);
            state_r <= ST_CMD_P;
          end
        end
        ST_CMD_P: begin
          if (mul_done) begin
            pitch_cmd_r <= tcf_pkg::sat180(cmd_v);
            state_r     <= ST_FIN;
          end
        end
        ST_FIN: begin
          // Advance only once the output register is free.
          if (out_free) begin
            out_r.roll_angle    <= roll_est_r;
            out_r.pitch_angle   <= pitch_est_r;
            out_r.roll_command  <= last_roll_cmd_r;
            out_r.pitch_command <= pitch_cmd_r;
            state_r             <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `TCF_ASSERT_IMPL(a_mul_start_free, clk, rst_n, mul_start, !mul_busy && !mul_done)
  `TCF_ASSERT_IMPL(a_cord_start_free, clk, rst_n, cord_start, !cord_busy && !cord_done)
  `TCF_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, in_stall)
  `TCF_ASSERT_IMPL(a_roll_cmd_range, clk, rst_n, 1'b1, last_roll_cmd_r <= 8'd180)

endmodule
